@@ src/ippc_pkg.sv @@
package ippc_pkg;

    // Counter table geometry
    localparam int PROTOCOL_ENTRIES = 256;
    localparam int COUNT_BITS       = 64;
    localparam int IDX_BITS         = $clog2(PROTOCOL_ENTRIES);
    localparam int COUNT_PORT_BITS  = 64;

    // Command queue between parser and counter engine
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Packet parsing
    localparam int OFFSET_BITS          = 7;
    localparam logic [6:0] OFFSET_MAX   = 7'd127;
    localparam logic [6:0] TYPE_HI_POS  = 7'd12;
    localparam logic [6:0] TYPE_LO_POS  = 7'd13;
    localparam logic [6:0] INNER_HI_POS = 7'd16;
    localparam logic [6:0] INNER_LO_POS = 7'd17;
    localparam logic [6:0] ETH_HDR_LEN  = 7'd14;
    localparam logic [6:0] VLAN_HDR_END = 7'd18;
    localparam logic [6:0] IPV4_PROTO_POS = 7'd9;
    localparam logic [6:0] IPV6_NEXT_POS  = 7'd6;
    localparam logic [7:0] IPV4_MIN_LEN   = 8'd20;
    localparam logic [7:0] IPV6_MIN_LEN   = 8'd40;

    localparam logic [15:0] TYPE_VLAN_Q  = 16'h8100;
    localparam logic [15:0] TYPE_VLAN_AD = 16'h88A8;
    localparam logic [15:0] TYPE_IPV4    = 16'h0800;
    localparam logic [15:0] TYPE_IPV6    = 16'h86DD;

    // Item and result codes
    localparam logic OP_BYTE      = 1'b0;
    localparam logic OP_READ      = 1'b1;
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_READ    = 1'b1;
    localparam logic VERDICT_PASS = 1'b0;
    localparam logic VERDICT_DROP = 1'b1;

    // One request for the counter engine
    typedef struct packed {
        logic                kind;
        logic                verdict;
        logic                count_en;
        logic [IDX_BITS-1:0] index;
    } t_cmd;

endpackage

@@ src/ippc_ram.sv @@
module ippc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/ippc_front.sv @@
module ippc_front import ippc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_op,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic [7:0] i_counter_index,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic [15:0]            r_outer, n_outer;
    logic [15:0]            r_inner, n_inner;
    logic [7:0]             r_cap, n_cap;

    logic                   vlan;
    logic [OFFSET_BITS-1:0] hdr;
    logic [15:0]            etype;
    logic [7:0]             len;
    logic                   drop;
    logic [7:0]             proto;

    // Fold the current byte into the header fields
    always_comb begin
        n_outer = r_outer;
        n_inner = r_inner;
        if (r_offset == TYPE_HI_POS)  n_outer[15:8] = i_data_byte;
        if (r_offset == TYPE_LO_POS)  n_outer[7:0]  = i_data_byte;
        if (r_offset == INNER_HI_POS) n_inner[15:8] = i_data_byte;
        if (r_offset == INNER_LO_POS) n_inner[7:0]  = i_data_byte;

        vlan  = (n_outer == TYPE_VLAN_Q) || (n_outer == TYPE_VLAN_AD);
        hdr   = vlan ? VLAN_HDR_END : ETH_HDR_LEN;
        etype = vlan ? n_inner : n_outer;

        // Capture the protocol / next-header byte
        n_cap = r_cap;
        if (r_offset >= ETH_HDR_LEN) begin
            if ((etype == TYPE_IPV4) && (r_offset == hdr + IPV4_PROTO_POS)) n_cap = i_data_byte;
            if ((etype == TYPE_IPV6) && (r_offset == hdr + IPV6_NEXT_POS))  n_cap = i_data_byte;
        end

        n_offset = (r_offset < OFFSET_MAX) ? r_offset + 7'd1 : r_offset;

        // Verdict at packet end
        len  = {1'b0, r_offset} + 8'd1;
        drop = (len < {1'b0, ETH_HDR_LEN}) || (vlan && (len < {1'b0, hdr}));
        proto = 8'd0;
        if (!drop) begin
            if ((etype == TYPE_IPV4) && (len >= {1'b0, hdr} + IPV4_MIN_LEN)) begin
                proto = n_cap;
            end else if ((etype == TYPE_IPV6) && (len >= {1'b0, hdr} + IPV6_MIN_LEN)) begin
                proto = n_cap;
            end
        end
    end

    // Advance parse state; clear it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_outer  <= '0;
            r_inner  <= '0;
            r_cap    <= '0;
        end else if (i_accept && (i_op == OP_BYTE)) begin
            if (i_last_byte) begin
                r_offset <= '0;
                r_outer  <= '0;
                r_inner  <= '0;
                r_cap    <= '0;
            end else begin
                r_offset <= n_offset;
                r_outer  <= n_outer;
                r_inner  <= n_inner;
                r_cap    <= n_cap;
            end
        end
    end

    // Issue a request for reads and packet ends
    always_comb begin
        o_push = i_accept && ((i_op == OP_READ) || i_last_byte);
        if (i_op == OP_READ) begin
            o_cmd.kind     = KIND_READ;
            o_cmd.verdict  = VERDICT_PASS;
            o_cmd.count_en = 1'b0;
            o_cmd.index    = IDX_BITS'(i_counter_index);
        end else begin
            o_cmd.kind     = KIND_VERDICT;
            o_cmd.verdict  = drop ? VERDICT_DROP : VERDICT_PASS;
            o_cmd.count_en = !drop;
            o_cmd.index    = IDX_BITS'(proto);
        end
    end

endmodule

@@ src/ippc_fifo.sv @@
module ippc_fifo import ippc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr, r_rd;
    logic [QPTR_BITS:0]   r_count;

    assign o_full  = (r_count == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    // Store requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Move pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop) r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

endmodule

@@ src/ippc_back.sv @@
module ippc_back import ippc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    input  t_cmd                       i_q_cmd,
    output logic                       o_q_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_kind,
    output logic                       o_verdict,
    output logic [7:0]                 o_protocol,
    output logic [COUNT_PORT_BITS-1:0] o_count_value
);

    logic                  r_s1_v;
    t_cmd                  r_s1_cmd;
    logic [PROTOCOL_ENTRIES-1:0] r_valid;
    logic                  r_fwd_v;
    logic [IDX_BITS-1:0]   r_fwd_addr;
    logic [COUNT_BITS-1:0] r_fwd_data;

    logic                  r_out_v;
    logic                  r_out_kind;
    logic                  r_out_verdict;
    logic [7:0]            r_out_proto;
    logic [COUNT_BITS-1:0] r_out_count;

    logic                  out_free;
    logic                  advance;
    logic                  s1_fire;
    logic                  we;
    logic [COUNT_BITS-1:0] rdata;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] inc;

    assign out_free = !r_out_v || i_ready;
    assign advance  = !r_s1_v || out_free;
    assign s1_fire  = r_s1_v && out_free;
    assign o_q_pop  = advance && !i_q_empty;

    ippc_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(PROTOCOL_ENTRIES)
    ) u_counts (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_s1_cmd.index),
        .i_wdata(inc),
        .i_re   (o_q_pop),
        .i_raddr(i_q_cmd.index),
        .o_rdata(rdata)
    );

    // Resolve current count: forward last write, unwritten entries read zero
    always_comb begin
        if (r_fwd_v && (r_fwd_addr == r_s1_cmd.index)) begin
            cur = r_fwd_data;
        end else if (r_valid[r_s1_cmd.index]) begin
            cur = rdata;
        end else begin
            cur = '0;
        end
        inc = cur + 1'b1;
        we  = s1_fire && (r_s1_cmd.kind == KIND_VERDICT) && r_s1_cmd.count_en;
    end

    // Hold the request whose RAM read is in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (advance) begin
            r_s1_v <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_cmd <= i_q_cmd;
        end
    end

    // Track written entries and the latest write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fwd_v <= 1'b0;
        end else if (we) begin
            r_valid[r_s1_cmd.index] <= 1'b1;
            r_fwd_v                 <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_fwd_addr <= r_s1_cmd.index;
            r_fwd_data <= inc;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_fire) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_kind <= r_s1_cmd.kind;
            if (r_s1_cmd.kind == KIND_READ) begin
                r_out_verdict <= VERDICT_PASS;
                r_out_proto   <= '0;
                r_out_count   <= cur;
            end else begin
                r_out_verdict <= r_s1_cmd.verdict;
                r_out_proto   <= 8'(r_s1_cmd.index);
                r_out_count   <= '0;
            end
        end
    end

    assign o_valid       = r_out_v;
    assign o_kind        = r_out_kind;
    assign o_verdict     = r_out_verdict;
    assign o_protocol    = r_out_proto;
    assign o_count_value = COUNT_PORT_BITS'(r_out_count);

endmodule

@@ src/ip_protocol_packet_counter.sv @@
// Ethernet/VLAN/IP protocol histogram. Takes one request per cycle unless
// the queue is full: a packet byte (with a last-byte flag) or a counter
// read. The parser finds the EtherType, skips one 802.1Q/802.1AD tag, and
// picks up the IPv4 protocol or IPv6 next-header byte; on the last byte it
// issues a verdict (drop for a truncated Ethernet or VLAN header) and, on
// pass, bumps the 256 x 64-bit counter of the found protocol (0 when none).
// Reads and packet ends go through a 4-entry queue into a counter engine
// that does a read-modify-write on a single-port-write RAM with a forwarded
// last write, so it sustains one request per cycle unless the output stalls;
// the result is registered. Non-final bytes give no result. Counters reset
// to zero through per-entry valid bits, so there is no clearing pass.
module ip_protocol_packet_counter import ippc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [7:0]  i_counter_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic        o_verdict,
    output logic [7:0]  o_protocol,
    output logic [63:0] o_count_value
);

    logic accept;
    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_cmd q_cmd;

    assign o_ready = !q_full;
    assign accept  = i_valid && o_ready;

    ippc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_op           (i_op),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_counter_index(i_counter_index),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    ippc_fifo u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_cmd),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_data (q_cmd),
        .o_empty(q_empty)
    );

    ippc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_cmd      (q_cmd),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_verdict    (o_verdict),
        .o_protocol   (o_protocol),
        .o_count_value(o_count_value)
    );

endmodule
